### rtl/positional_list_insert_remove_unit_assert.svh
// Assertion macros for the positional list unit.
// Included by the top level; no other dependencies.
`ifndef POSITIONAL_LIST_INSERT_REMOVE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_REMOVE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define PLI_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("positional list: sequenced check failed");
`define PLI_ASSERT_ALWAYS(label, clk, dis, cond) \
    label: assert property (@(posedge clk) disable iff (dis) (cond)) \
        else $error("positional list: invariant check failed");
`else
`define PLI_ASSERT_NEXT(label, clk, dis, ante, cons)
`define PLI_ASSERT_ALWAYS(label, clk, dis, cond)
`endif
`endif

### rtl/pli_pkg.sv
// Shared types and codes for the positional list unit.
// No dependencies; used by pli_cell and the top level.
package pli_pkg;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [6:0]         position;
        logic signed [31:0] value;
    } t_item;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [6:0]         entry_count;
        logic [1:0]         status;
    } t_result;

    // Broadcast from the control logic to every cell of the row.
    typedef struct packed {
        logic       ins_en;
        logic       rem_en;
        logic       rd_en;
        logic [6:0] pos_idx;
    } t_cell_ctl;

endpackage

### rtl/pli_cell.sv
// One storage cell of the positional list row.
// Depends on pli_pkg for the broadcast control type.
module pli_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  pli_pkg::t_cell_ctl i_ctl,
    input  logic signed [31:0] i_left,
    input  logic signed [31:0] i_right,
    input  logic signed [31:0] i_value,
    output logic signed [31:0] o_data,
    output logic signed [31:0] o_tap
);
    import pli_pkg::*;

    logic signed [31:0] r_data;
    logic               at_pos;
    logic               after_pos;

    assign at_pos    = (32'(i_ctl.pos_idx) == 32'(IDX));
    assign after_pos = (32'(i_ctl.pos_idx) < 32'(IDX));

    // An insert opens a gap by pulling from the left; a remove closes it from the right.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_en) begin
            if (at_pos) begin
                r_data <= i_value;
            end else if (after_pos) begin
                r_data <= i_left;
            end
        end else if (i_ctl.rem_en && (at_pos || after_pos)) begin
            r_data <= i_right;
        end
    end

    assign o_data = r_data;
    assign o_tap  = (i_ctl.rd_en && at_pos) ? r_data : '0;

endmodule

### rtl/positional_list_insert_remove_unit.sv
// Top level of the positional list unit: control, count and the row of cells.
// Depends on pli_pkg, pli_cell and positional_list_insert_remove_unit_assert.svh.
//
// Holds an ordered list of up to DEPTH signed 32-bit words, addressed by
// 1-based position. A request is taken when start is high and busy is low;
// busy is set by reset and cleared by the first clock out of reset, so a new
// request can be issued every cycle while busy is low. Each request yields
// exactly one result word, shown on o_result for one cycle with o_strobe
// high, in the cycle after the request is taken. Every entry lives in its
// own cell and all cells shift in the same cycle, so an insert, remove or
// read takes the same time whatever the position. The result cannot be held
// off and must be captured when o_strobe is high.
`include "positional_list_insert_remove_unit_assert.svh"
module positional_list_insert_remove_unit #(
    parameter int DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pli_pkg::t_item    i_item,
    output logic              o_strobe,
    output pli_pkg::t_result  o_result
);
    import pli_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ((CW > 7) ? CW : 7) + 1;

    logic              r_busy;
    logic              r_strobe;
    logic [CW-1:0]     r_count;
    t_result           r_result;

    logic [CW-1:0]     n_count;
    logic [1:0]        n_status;
    logic              accept;
    logic              pos_zero;
    logic              in_list;
    logic              ins_range;
    logic              full;
    logic [PW-1:0]     pos_w;
    logic [PW-1:0]     cnt_w;
    logic [PW-1:0]     n_count_w;
    logic signed [31:0] tap_or;
    t_cell_ctl         ctl;

    logic signed [31:0] cell_data [DEPTH];
    logic signed [31:0] cell_tap  [DEPTH];

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    assign pos_w     = PW'(i_item.position);
    assign cnt_w     = PW'(r_count);
    assign pos_zero  = (i_item.position == '0);
    assign in_list   = !pos_zero && (pos_w <= cnt_w);
    assign ins_range = !pos_zero && (pos_w <= cnt_w + PW'(1));
    assign full      = (r_count == CW'(DEPTH));

    always_comb begin
        ctl         = '0;
        ctl.pos_idx = i_item.position - 7'd1;
        n_status    = ST_DONE;
        n_count     = r_count;
        unique case (i_item.action)
            ACT_INSERT: begin
                if (!ins_range) begin
                    n_status = ST_RANGE;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ctl.ins_en = accept;
                    n_count    = r_count + CW'(1);
                end
            end
            ACT_REMOVE: begin
                if (!in_list) begin
                    n_status = ST_RANGE;
                end else begin
                    ctl.rem_en = accept;
                    ctl.rd_en  = 1'b1;
                    n_count    = r_count - CW'(1);
                end
            end
            ACT_READ: begin
                if (!in_list) begin
                    n_status = ST_RANGE;
                end else begin
                    ctl.rd_en = 1'b1;
                end
            end
            default: begin
                n_status = ST_RANGE;
            end
        endcase
    end

    assign n_count_w = PW'(n_count);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic signed [31:0] left_w;
            logic signed [31:0] right_w;
            if (gi == 0) begin : g_first
                assign left_w = i_item.value;
            end else begin : g_mid_l
                assign left_w = cell_data[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign right_w = cell_data[gi];
            end else begin : g_mid_r
                assign right_w = cell_data[gi+1];
            end
            pli_cell #(
                .IDX (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_left  (left_w),
                .i_right (right_w),
                .i_value (i_item.value),
                .o_data  (cell_data[gi]),
                .o_tap   (cell_tap[gi])
            );
        end
    endgenerate

    // At most one cell drives a non-zero tap, so an OR gathers the word read.
    always_comb begin
        tap_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            tap_or = tap_or | cell_tap[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_strobe <= 1'b0;
            r_count  <= '0;
        end else begin
            r_busy   <= 1'b0;
            r_strobe <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result.read_value  <= tap_or;
            r_result.entry_count <= n_count_w[6:0];
            r_result.status      <= n_status;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `PLI_ASSERT_NEXT(a_strobe_follows, i_clk, (!i_rst_n || r_busy), accept, o_strobe)
    `PLI_ASSERT_NEXT(a_no_stray_strobe, i_clk, (!i_rst_n || r_busy), !accept, !o_strobe)
    `PLI_ASSERT_ALWAYS(a_count_bound, i_clk, (!i_rst_n || r_busy), (cnt_w <= PW'(DEPTH)))
    `PLI_ASSERT_NEXT(a_count_step, i_clk, (!i_rst_n || r_busy), 1'b1, ((cnt_w == $past(cnt_w)) || (cnt_w == $past(cnt_w) + PW'(1)) || (cnt_w + PW'(1) == $past(cnt_w))))

endmodule
